// ===== hdl/rtfp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtfp_pkg
// Shared constants, register codes and field helpers for the radar target
// frame parser.
// ----------------------------------------------------------------------------
package rtfp_pkg;

  localparam int          FRAME_BYTES_DEFAULT = 30;
  localparam int          HEADER_BYTES        = 4;
  localparam int          SLOTS               = 3;
  localparam int          SLOT_BYTES          = 8;
  localparam int          PADDR_W             = 4;
  localparam int          PDATA_W             = 32;

  localparam logic [31:0] HEADER_RESET = 32'h0003_FFAA;
  localparam logic [15:0] FOOTER_RESET = 16'hCC55;
  localparam logic [15:0] MAG_MASK     = 16'h7FFF;
  localparam logic [7:0]  SIGN_BIT     = 8'h80;

  typedef enum logic [1:0] {
    REG_HEADER = 2'd0,
    REG_FOOTER = 2'd1,
    REG_MODE   = 2'd2
  } reg_idx_t;

  // sign-magnitude word, set top bit means positive
  function automatic logic [15:0] sm_to_field(input logic [7:0] lo, input logic [7:0] hi);
    logic [15:0] mag;
    mag = {hi, lo} & MAG_MASK;
    if ((hi & SIGN_BIT) != 8'd0) begin
      return mag;
    end
    return 16'd0 - mag;
  endfunction

endpackage

// ===== hdl/radar_target_frame_parser_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radar_target_frame_parser_core
// Header-synced fixed-length frame parser, three target reports per good frame.
// ----------------------------------------------------------------------------
// Usage:
//  rx channel : one byte per request (rx_byte), rx_valid / rx_stall.
//  result     : status, slot, target fields, target_count, last per request,
//               res_valid / res_stall.
//  APB port   : 0x0 header pattern, 0x4 footer pattern, 0x8 config mode.
// Throughput: one byte per cycle. Bytes inside a frame are never stalled.
//  rx_stall rises only on the final byte of a frame while the results of the
//  previous frame are still being read out.
// Unload: results of a frame follow its final byte; each goes through the slot
//  memory read, then the output register, and a read waits for the one before
//  it to land. Three results per good frame, one on a footer mismatch.
// Target slots are collected in a two-bank slot memory, one 64-bit word per
//  slot, so the next frame fills one bank while the other is unloaded.
// Reset (rst, synchronous): registers to their defaults, hunt window zero,
//  not synced, no results pending. The slot memory needs no clearing since
//  every slot is written before its frame ends.
// A stalled result holds; the next frame's bytes keep flowing meanwhile.
// ----------------------------------------------------------------------------
module radar_target_frame_parser_core #(
  parameter int FRAME_BYTES = rtfp_pkg::FRAME_BYTES_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  // received byte channel
  input  logic [7:0]                   rx_byte,
  input  logic                         rx_valid,
  output logic                         rx_stall,
  // result channel
  output logic                         status,
  output logic [1:0]                   slot,
  output logic                         target_valid,
  output logic signed [15:0]           pos_x,
  output logic signed [15:0]           pos_y,
  output logic signed [15:0]           velocity,
  output logic [15:0]                  resolution,
  output logic [1:0]                   target_count,
  output logic                         last,
  output logic                         res_valid,
  input  logic                         res_stall,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rtfp_pkg::PADDR_W-1:0] paddr,
  input  logic [rtfp_pkg::PDATA_W-1:0] pwdata,
  output logic [rtfp_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);

  localparam int IDX_W     = $clog2(FRAME_BYTES);
  localparam int SLOT_W    = 64;
  localparam int MEM_DEPTH = 2 * rtfp_pkg::SLOTS;
  localparam int MADDR_W   = $clog2(MEM_DEPTH);

  // ---------------------------------------------------------------- config
  logic [31:0]        header_pattern;
  logic [15:0]        footer_pattern;
  logic               config_mode;
  rtfp_pkg::reg_idx_t cfg_idx;
  logic               cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = rtfp_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_pattern <= rtfp_pkg::HEADER_RESET;
      footer_pattern <= rtfp_pkg::FOOTER_RESET;
      config_mode    <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        rtfp_pkg::REG_HEADER: header_pattern <= pwdata;
        rtfp_pkg::REG_FOOTER: footer_pattern <= pwdata[15:0];
        rtfp_pkg::REG_MODE:   config_mode    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      rtfp_pkg::REG_HEADER: prdata = header_pattern;
      rtfp_pkg::REG_FOOTER: prdata = {16'd0, footer_pattern};
      rtfp_pkg::REG_MODE:   prdata = {31'd0, config_mode};
      default:              prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- byte side
  logic [31:0]      win;          // hunt window, oldest byte in [7:0]
  logic [31:0]      win_next;
  logic             synced;
  logic [IDX_W-1:0] byte_index;
  logic [1:0]       slot_cnt;     // SLOTS once all target bytes are in
  logic [2:0]       lane_cnt;
  logic [55:0]      asm_buf;      // first seven bytes of the current slot
  logic [7:0]       prev_byte;
  logic [1:0]       valid_cnt;
  logic             wr_bank;

  logic             rx_accept;
  logic             byte_en;
  logic             frame_end;
  logic             wr_en;
  logic [SLOT_W-1:0] wr_word;
  logic [MADDR_W-1:0] wr_addr;

  // unload job
  logic             job_active;
  logic             job_bank;
  logic             job_err;
  logic [1:0]       job_count;
  logic [1:0]       job_slot;
  logic             issue;
  logic [MADDR_W-1:0] rd_addr;

  function automatic logic [MADDR_W-1:0] mem_addr(input logic bank, input logic [1:0] s);
    return bank ? MADDR_W'(rtfp_pkg::SLOTS) + MADDR_W'(s) : MADDR_W'(s);
  endfunction

  assign frame_end = synced && !config_mode && (byte_index == IDX_W'(FRAME_BYTES - 1));
  assign rx_stall  = job_active && frame_end;
  assign rx_accept = rx_valid && !rx_stall;
  assign byte_en   = rx_accept && !config_mode;
  assign win_next  = {rx_byte, win[31:8]};

  assign wr_en   = byte_en && synced && (slot_cnt != 2'(rtfp_pkg::SLOTS)) && (lane_cnt == 3'd7);
  assign wr_word = {rx_byte, asm_buf};
  assign wr_addr = mem_addr(wr_bank, slot_cnt);

  always_ff @(posedge clk) begin
    if (rst) begin
      win        <= '0;
      synced     <= 1'b0;
      byte_index <= '0;
      slot_cnt   <= '0;
      lane_cnt   <= '0;
      valid_cnt  <= '0;
      wr_bank    <= 1'b0;
    end else if (byte_en) begin
      if (!synced) begin
        win <= win_next;
        if (win_next == header_pattern) begin
          synced     <= 1'b1;
          byte_index <= IDX_W'(rtfp_pkg::HEADER_BYTES);
          slot_cnt   <= '0;
          lane_cnt   <= '0;
          valid_cnt  <= '0;
        end
      end else begin
        byte_index <= byte_index + 1'b1;
        if (slot_cnt != 2'(rtfp_pkg::SLOTS)) begin
          lane_cnt <= lane_cnt + 1'b1;
          if (lane_cnt == 3'd7) begin
            slot_cnt <= slot_cnt + 1'b1;
            if (wr_word != '0) begin
              valid_cnt <= valid_cnt + 1'b1;
            end
          end
        end
        if (frame_end) begin
          synced     <= 1'b0;
          byte_index <= '0;
          wr_bank    <= !wr_bank;
        end
      end
    end
  end

  // payload side of the assembler
  always_ff @(posedge clk) begin
    if (byte_en && synced) begin
      prev_byte <= rx_byte;
      if (lane_cnt != 3'd7) begin
        asm_buf[8*lane_cnt +: 8] <= rx_byte;
      end
    end
  end

  // ---------------------------------------------------------------- slot memory
  logic [SLOT_W-1:0] slot_mem [MEM_DEPTH];
  logic [SLOT_W-1:0] rd_word;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[wr_addr] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_word <= slot_mem[rd_addr];
    end
  end

  // ---------------------------------------------------------------- unload
  logic       rd_vld;
  logic       rd_err;
  logic [1:0] rd_slot;
  logic       rd_last;
  logic [1:0] rd_count;
  logic       issue_last;

  // a read is issued only when the output register is free the cycle its data lands
  assign issue      = job_active && !rd_vld && (!res_valid || !res_stall);
  assign issue_last = job_err || (job_slot == 2'(rtfp_pkg::SLOTS - 1));
  assign rd_addr    = mem_addr(job_bank, job_slot);

  always_ff @(posedge clk) begin
    if (rst) begin
      job_active <= 1'b0;
      rd_vld     <= 1'b0;
    end else begin
      rd_vld <= issue;
      if (byte_en && frame_end) begin
        job_active <= 1'b1;
      end else if (issue && issue_last) begin
        job_active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (byte_en && frame_end) begin
      job_bank  <= wr_bank;
      job_err   <= {rx_byte, prev_byte} != footer_pattern;
      job_count <= valid_cnt;
      job_slot  <= '0;
    end else if (issue) begin
      job_slot <= job_slot + 1'b1;
    end
    if (issue) begin
      rd_err   <= job_err;
      rd_slot  <= job_slot;
      rd_last  <= issue_last;
      rd_count <= job_count;
    end
  end

  // ---------------------------------------------------------------- result register
  logic        dec_any;
  logic [15:0] dec_x;
  logic [15:0] dec_y;
  logic [15:0] dec_v;
  logic [15:0] dec_r;

  always_comb begin
    dec_any = (rd_word != '0) && !rd_err;
    dec_x   = rtfp_pkg::sm_to_field(rd_word[7:0],   rd_word[15:8]);
    dec_y   = rtfp_pkg::sm_to_field(rd_word[23:16], rd_word[31:24]);
    dec_v   = rtfp_pkg::sm_to_field(rd_word[39:32], rd_word[47:40]);
    dec_r   = rd_word[63:48];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (rd_vld) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld) begin
      status       <= rd_err;
      slot         <= rd_err ? 2'd0 : rd_slot;
      target_valid <= dec_any;
      pos_x        <= dec_any ? dec_x : 16'sd0;
      pos_y        <= dec_any ? dec_y : 16'sd0;
      velocity     <= dec_any ? dec_v : 16'sd0;
      resolution   <= dec_any ? dec_r : 16'd0;
      target_count <= rd_err ? 2'd0 : rd_count;
      last         <= rd_last;
    end
  end

`ifndef SYNTHESIS
  // returning read data always finds the output register free
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> !(res_valid && res_stall))
    else $error("slot read landed on a stalled result");

  a_land: assert property (@(posedge clk) disable iff (rst)
    rd_vld |=> res_valid)
    else $error("slot read lost");

  // the filling bank never is the one being unloaded
  a_bank: assert property (@(posedge clk) disable iff (rst)
    (wr_en && job_active) |-> (wr_bank != job_bank))
    else $error("slot write hit the bank under unload");

  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    (res_valid && status) |-> (last && slot == 2'd0 && !target_valid))
    else $error("malformed error result");
`endif

endmodule

// ===== sim/tb_radar_target_frame_parser_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_radar_target_frame_parser_core
// Self-checking bench for the radar frame parser: byte stream in, target
// reports out, predicted in-bench and compared field by field in order.
// ----------------------------------------------------------------------------
module tb_radar_target_frame_parser_core;

  localparam int FRAME_LEN = rtfp_pkg::FRAME_BYTES_DEFAULT;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic        status;
    logic [1:0]  slot;
    logic        tvalid;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] v;
    logic [15:0] res;
    logic [1:0]  count;
    logic        last;
  } target_rpt_t;

  // DUT connections, all inputs known from time zero
  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic [7:0]                   rx_byte = '0;
  logic                         rx_valid = 1'b0;
  logic                         rx_stall;
  logic                         status;
  logic [1:0]                   slot;
  logic                         target_valid;
  logic signed [15:0]           pos_x;
  logic signed [15:0]           pos_y;
  logic signed [15:0]           velocity;
  logic [15:0]                  resolution;
  logic [1:0]                   target_count;
  logic                         last;
  logic                         res_valid;
  logic                         res_stall = 1'b0;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [rtfp_pkg::PADDR_W-1:0] paddr = '0;
  logic [rtfp_pkg::PDATA_W-1:0] pwdata = '0;
  logic [rtfp_pkg::PDATA_W-1:0] prdata;
  logic                         pready;

  // bench-side copy of the parser: registers, hunt window / frame buffer
  logic [31:0]          hdr_q = rtfp_pkg::HEADER_RESET;
  logic [15:0]          ftr_q = rtfp_pkg::FOOTER_RESET;
  logic                 mode_q = 1'b0;
  logic [7:0]           rx_buf [FRAME_LEN];
  logic                 in_sync = 1'b0;
  int                   buf_idx = 0;

  target_rpt_t          pending_reports [$];
  target_rpt_t          want_rpt;
  int                   mismatch_cnt = 0;

  // traffic shaping knobs: idle and stall in percent of cycles, plus the hold-off request
  int                   send_idle_pct = 0;
  int                   recv_stall_pct = 0;
  int                   hold_asked = 0;
  int                   hold_taken = 0;
  int                   hold_left = 0;

  radar_target_frame_parser_core #(.FRAME_BYTES(FRAME_LEN)) DUT (
    .clk          (clk),
    .rst          (rst),
    .rx_byte      (rx_byte),
    .rx_valid     (rx_valid),
    .rx_stall     (rx_stall),
    .status       (status),
    .slot         (slot),
    .target_valid (target_valid),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .velocity     (velocity),
    .resolution   (resolution),
    .target_count (target_count),
    .last         (last),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #2 clk = ~clk;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // sign-magnitude word: top bit set -> positive, clear -> negative
  function automatic logic [15:0] sm_decode(logic [7:0] lo, logic [7:0] hi);
    logic [15:0] mag;
    mag = {1'b0, hi[6:0], lo};
    return hi[7] ? mag : 16'h0000 - mag;
  endfunction

  // advance the bench copy by one accepted byte, queue any reports it causes
  function automatic void parse_rx_byte(logic [7:0] b);
    target_rpt_t rpt [3];
    target_rpt_t err_rpt;
    logic [63:0] tgt;
    logic [1:0]  n_valid;
    int          k;
    int          i;

    if (mode_q) return;  // config mode: byte dropped, no state change

    if (!in_sync) begin
      // hunting: slide the four-byte window, oldest byte first
      for (i = 0; i < rtfp_pkg::HEADER_BYTES - 1; i++) rx_buf[i] = rx_buf[i+1];
      rx_buf[rtfp_pkg::HEADER_BYTES-1] = b;
      if ({rx_buf[3], rx_buf[2], rx_buf[1], rx_buf[0]} == hdr_q) begin
        in_sync = 1'b1;
        buf_idx = rtfp_pkg::HEADER_BYTES;
      end
      return;
    end

    if (buf_idx >= FRAME_LEN) return;
    rx_buf[buf_idx] = b;
    buf_idx++;
    if (buf_idx != FRAME_LEN) return;

    // frame complete; window keeps the header bytes for the next hunt
    in_sync = 1'b0;
    buf_idx = 0;

    if ({rx_buf[FRAME_LEN-1], rx_buf[FRAME_LEN-2]} != ftr_q) begin
      err_rpt = '0;
      err_rpt.status = 1'b1;
      err_rpt.last = 1'b1;
      pending_reports.push_back(err_rpt);
      return;
    end

    n_valid = '0;
    for (k = 0; k < rtfp_pkg::SLOTS; k++) begin
      for (i = 0; i < rtfp_pkg::SLOT_BYTES; i++)
        tgt[8*i +: 8] = rx_buf[rtfp_pkg::HEADER_BYTES + rtfp_pkg::SLOT_BYTES*k + i];
      rpt[k] = '0;
      rpt[k].slot = k[1:0];
      if (tgt != 64'd0) begin
        rpt[k].tvalid = 1'b1;
        rpt[k].x = sm_decode(tgt[7:0], tgt[15:8]);
        rpt[k].y = sm_decode(tgt[23:16], tgt[31:24]);
        rpt[k].v = sm_decode(tgt[39:32], tgt[47:40]);
        rpt[k].res = tgt[63:48];
        n_valid++;
      end
    end
    for (k = 0; k < rtfp_pkg::SLOTS; k++) begin
      rpt[k].count = n_valid;
      rpt[k].last = (k == rtfp_pkg::SLOTS - 1);
      pending_reports.push_back(rpt[k]);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------

  function automatic void cmp_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      mismatch_cnt++;
      $display("%0t: %s mismatch, expected 0x%04h, actual 0x%04h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (pending_reports.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: report with none expected, expected nothing, actual slot %0d status %0b",
                 $time, slot, status);
      end else begin
        want_rpt = pending_reports.pop_front();
        cmp_field("status", want_rpt.status, status);
        cmp_field("slot", want_rpt.slot, slot);
        cmp_field("target_valid", want_rpt.tvalid, target_valid);
        cmp_field("pos_x", want_rpt.x, pos_x);
        cmp_field("pos_y", want_rpt.y, pos_y);
        cmp_field("velocity", want_rpt.v, velocity);
        cmp_field("resolution", want_rpt.res, resolution);
        cmp_field("target_count", want_rpt.count, target_count);
        cmp_field("last", want_rpt.last, last);
      end
    end
  end

  // Result-side stall: random per cycle, or a long hold-off when one is asked
  // for. The hold is counted here so only this process drives res_stall.
  always @(posedge clk) begin
    if (hold_taken != hold_asked) begin
      hold_taken = hold_asked;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_stall <= 1'b1;
    end else begin
      res_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // One byte request. Called at a clock edge; returns at the edge where the
  // byte was taken. valid stays high into the next call unless it idles.
  task automatic send_rx(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      rx_valid <= 1'b0;
      @(posedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (rx_stall);
    parse_rx_byte(b);
  endtask

  // Drop valid, wait for every pending report, then let in-flight bytes settle.
  task automatic drain_reports();
    rx_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // APB write, then read back and check the stored value
  task automatic reg_write(input rtfp_pkg::reg_idx_t r, input logic [31:0] val);
    logic [31:0] mask;
    logic [31:0] rd;
    case (r)
      rtfp_pkg::REG_HEADER: mask = 32'hFFFF_FFFF;
      rtfp_pkg::REG_FOOTER: mask = 32'h0000_FFFF;
      default:              mask = 32'h0000_0001;
    endcase
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (r)
      rtfp_pkg::REG_HEADER: hdr_q = val;
      rtfp_pkg::REG_FOOTER: ftr_q = val[15:0];
      default:              mode_q = val[0];
    endcase
    // readback
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if ((rd & mask) !== (val & mask)) begin
      mismatch_cnt++;
      $display("%0t: register %s readback, expected 0x%08h, actual 0x%08h",
               $time, r.name(), val & mask, rd & mask);
    end
  endtask

  // header (stops early once synced, so periodic headers stay aligned),
  // three slots, footer. Any open frame is flushed with random bytes first.
  task automatic send_frame(input logic [63:0] s0, input logic [63:0] s1,
                            input logic [63:0] s2, input logic [15:0] ftr);
    logic [191:0] body;
    int           i;
    body = {s2, s1, s0};
    while (in_sync) send_rx($urandom_range(255));
    for (i = 0; i < rtfp_pkg::HEADER_BYTES; i++)
      if (!in_sync) send_rx(hdr_q[8*i +: 8]);
    for (i = 0; i < rtfp_pkg::SLOTS * rtfp_pkg::SLOT_BYTES; i++) send_rx(body[8*i +: 8]);
    send_rx(ftr[7:0]);
    send_rx(ftr[15:8]);
  endtask

  function automatic logic [7:0] edge_byte();
    case ($urandom_range(3))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      default: return 8'h7F;
    endcase
  endfunction

  // slot content: empty, random, corner bytes, or a single non-zero byte
  function automatic logic [63:0] rand_slot();
    logic [63:0] s;
    int          i;
    case ($urandom_range(3))
      0: s = '0;
      1: s = {$urandom, $urandom};
      2: for (i = 0; i < rtfp_pkg::SLOT_BYTES; i++) s[8*i +: 8] = edge_byte();
      default: s = 64'($urandom_range(255, 1)) << (8 * $urandom_range(rtfp_pkg::SLOT_BYTES - 1));
    endcase
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // corner target words with the reset header/footer: max and min magnitudes,
  // plus and minus zero, an all-zero slot in the middle
  task automatic test_target_corners();
    send_frame(64'hFFFF_0000_7FFF_FFFF, 64'h0, 64'h1234_0001_8001_8000, ftr_q);
    drain_reports();
  endtask

  // wrong footer gives a single error report
  task automatic test_footer_mismatch();
    send_frame(rand_slot(), rand_slot(), rand_slot(), ftr_q ^ 16'h0100);
    drain_reports();
  endtask

  // config mode drops every byte, even a full header; the next frame shows
  // that the hunt state was left alone
  task automatic test_config_mode();
    int i;
    reg_write(rtfp_pkg::REG_MODE, 32'd1);
    for (i = 0; i < rtfp_pkg::HEADER_BYTES; i++) send_rx(hdr_q[8*i +: 8]);
    send_rx(8'h00);
    send_rx(8'hFF);
    drain_reports();
    reg_write(rtfp_pkg::REG_MODE, 32'd0);
  endtask

  // after a frame the window still holds the header: with a repeating
  // header byte one more byte resyncs straight away
  task automatic test_window_resync();
    reg_write(rtfp_pkg::REG_HEADER, 32'h5A5A_5A5A);
    send_frame(rand_slot(), rand_slot(), rand_slot(), ftr_q);
    send_frame(rand_slot(), rand_slot(), rand_slot(), ftr_q);
    drain_reports();
  endtask

  // header rewritten while synced: the current frame still completes
  task automatic test_header_midframe();
    logic [191:0] body;
    int           i;
    reg_write(rtfp_pkg::REG_HEADER, rtfp_pkg::HEADER_RESET);
    body = {rand_slot(), rand_slot(), rand_slot()};
    while (in_sync) send_rx($urandom_range(255));
    for (i = 0; i < rtfp_pkg::HEADER_BYTES; i++)
      if (!in_sync) send_rx(hdr_q[8*i +: 8]);
    for (i = 0; i < 10; i++) send_rx(body[8*i +: 8]);
    drain_reports();
    reg_write(rtfp_pkg::REG_HEADER, 32'h1234_5678);
    for (i = 10; i < rtfp_pkg::SLOTS * rtfp_pkg::SLOT_BYTES; i++) send_rx(body[8*i +: 8]);
    send_rx(ftr_q[7:0]);
    send_rx(ftr_q[15:8]);
    drain_reports();
  endtask

  // all-ones and all-zero registers; an all-zero frame syncs on the zero
  // header and reports no valid target
  task automatic test_register_extremes();
    reg_write(rtfp_pkg::REG_HEADER, 32'hFFFF_FFFF);
    reg_write(rtfp_pkg::REG_FOOTER, 32'h0000_FFFF);
    reg_write(rtfp_pkg::REG_HEADER, 32'h0000_0000);
    reg_write(rtfp_pkg::REG_FOOTER, 32'h0000_0000);
    send_frame(64'h0, 64'h0, 64'h0, ftr_q);
    drain_reports();
  endtask

  // random frames under one idle/stall setting; mostly good frames,
  // some broken footers, some truncated frames and line noise between
  task automatic test_random_stream(input int idle_pct, input int stall_pct,
                                    input logic [31:0] hdr, input logic [15:0] ftr,
                                    input int n_frames);
    int n;
    int roll;
    int i;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    reg_write(rtfp_pkg::REG_HEADER, hdr);
    reg_write(rtfp_pkg::REG_FOOTER, {16'h0, ftr});
    for (n = 0; n < n_frames; n++) begin
      repeat ($urandom_range(3)) send_rx($urandom_range(255));
      roll = $urandom_range(99);
      if (roll < 10) begin
        // truncated: header then a short run; the next frame flushes it
        while (in_sync) send_rx($urandom_range(255));
        for (i = 0; i < rtfp_pkg::HEADER_BYTES; i++)
          if (!in_sync) send_rx(hdr_q[8*i +: 8]);
        repeat ($urandom_range(20)) send_rx($urandom_range(255));
      end else if (roll < 25) begin
        send_frame(rand_slot(), rand_slot(), rand_slot(), 16'($urandom));
      end else begin
        send_frame(rand_slot(), rand_slot(), rand_slot(), ftr_q);
      end
    end
    drain_reports();
  endtask

  // receiver holds off for a long stretch while frames keep coming,
  // so the parser has to stall the final byte of a frame
  task automatic test_output_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    reg_write(rtfp_pkg::REG_HEADER, rtfp_pkg::HEADER_RESET);
    reg_write(rtfp_pkg::REG_FOOTER, {16'h0, rtfp_pkg::FOOTER_RESET});
    hold_asked++;
    repeat (2) send_frame(rand_slot(), rand_slot(), rand_slot(), ftr_q);
    drain_reports();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    int i;
    int guard;
    for (i = 0; i < FRAME_LEN; i++) rx_buf[i] = 8'h00;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_target_corners();
    test_footer_mismatch();
    test_config_mode();
    test_window_resync();
    test_header_midframe();
    test_register_extremes();

    test_random_stream(80, 0, 32'hFFFF_FFFF, 16'hFFFF, 1);
    test_random_stream(0, 80, $urandom, 16'h0000, 1);
    test_random_stream(21, 21, 32'h0000_0000, 16'($urandom), 1);
    test_output_backpressure();

    // final drain, bounded
    rx_valid <= 1'b0;
    guard = 0;
    while (pending_reports.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    if (pending_reports.size() != 0) begin
      mismatch_cnt++;
      $display("%0t: %0d reports never arrived, expected slot %0d, actual none",
               $time, pending_reports.size(), pending_reports[0].slot);
    end
    if (mismatch_cnt == 0) begin
      $display("tb_radar_target_frame_parser_core: done, clean");
    end else begin
      $display("tb_radar_target_frame_parser_core: done, errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("tb_radar_target_frame_parser_core: done, errors");
    $finish;
  end

endmodule

// ===== radar_target_frame_parser_core.f =====
hdl/rtfp_pkg.sv
hdl/radar_target_frame_parser_core.sv
sim/tb_radar_target_frame_parser_core.sv
